/* design/tcw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, cell encoding, control characters and the state and
// action codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;

  localparam int COL_W  = $clog2(SCREEN_COLS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int POS_W  = 11;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 16;

  localparam logic [BYTE_W-1:0] SPACE_CHAR      = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE      = 8'd10;
  localparam logic [BYTE_W-1:0] CH_RETURN       = 8'd13;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE    = 8'd8;
  localparam logic [BYTE_W-1:0] BLANK_COLOR_RST = 8'h07;

  localparam logic [CELL_W-1:0] RESET_CELL = {BLANK_COLOR_RST, SPACE_CHAR};

  // Sweep bounds within the frame store
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS - 1);
  localparam logic [ADDR_W-1:0] TAIL_FIRST = ADDR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);

  typedef enum logic [2:0] {
    ST_INIT,   // clear the store after reset
    ST_IDLE,   // take items
    ST_READ,   // cell read data arrives
    ST_COPY,   // scroll: move rows up
    ST_BLANK,  // fill cells with the blank value
    ST_FIN     // deliver the result of a long item
  } tcw_state_t;

  typedef enum logic [1:0] {
    ACT_PUT    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SETCUR = 2'd2,
    ACT_READ   = 2'd3
  } tcw_action_t;

endpackage
`default_nettype wire

/* design/text_console_writer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a frame store and a cursor.
// ----------------------------------------------------------------------------
// The frame store is one 2000 x 16-bit synchronous memory (attribute in the
// high byte, character in the low byte) with one write and one read port.
// After reset the block runs a clearing pass over every cell, then retires
// the last write, and stalls input meanwhile; configuration writes are taken
// at all times. Printing a character, newline, backspace and set cursor
// finish in the idle state, so such items can follow back to back while the
// result register is free. A read waits in the read state for the registered
// memory data. A put that runs past the bottom row scrolls: it copies the
// rows up, blanks the last row and then delivers its result; clear screen
// blanks every cell and then delivers its result. These long items walk the
// store through the single memory write port, which moves one cell per
// cycle. Every item returns one result: the linear cursor position and, for
// a read, the cell. A result waits in an output register, and the next item
// is taken in the same cycle that the register is emptied.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [7:0]  in_color,
  input  wire logic [7:0]  in_col,
  input  wire logic [7:0]  in_row,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [10:0]      out_cursor_pos,
  output logic [15:0]      out_cell_data,
  // blank colour register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;
  localparam int ADDR_W = tcw_pkg::ADDR_W;
  localparam int POS_W  = tcw_pkg::POS_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  function automatic logic [ADDR_W-1:0] lin_of(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    lin_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(tcw_pkg::SCREEN_COLS)) + ADDR_W'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  tcw_pkg::tcw_state_t state_r, state_nxt;

  logic [7:0]        blank_color_r;
  logic [COL_W-1:0]  cur_col_r,  cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r,  cur_row_nxt;
  logic [ADDR_W-1:0] lin_r,      lin_nxt;
  logic [ADDR_W-1:0] scan_r,     scan_nxt;
  logic [ADDR_W-1:0] rd_addr_r,  rd_addr_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic              wr_pend_r,  wr_pend_nxt;
  logic              wr_copy_r,  wr_copy_nxt;
  logic [ADDR_W-1:0] wr_addr_r,  wr_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r,   out_pos_nxt;
  logic [CELL_W-1:0] out_cell_r,  out_cell_nxt;

  // Frame store
  logic [CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
  logic [CELL_W-1:0] rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic out_free;
  logic accept;
  tcw_pkg::tcw_action_t act;

  assign act      = tcw_pkg::tcw_action_t'(in_action);
  assign out_free = !out_valid_r || !out_stall;
  // Take an item only when idle, no sweep write is still in flight and the
  // result register can take a result in this cycle.
  assign in_stall = !((state_r == tcw_pkg::ST_IDLE) && !wr_pend_r && out_free);
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_cell_r;

  // --------------------------------------------------------------------------
  // Coordinate clamping for set cursor and read
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  row_clamp;
  logic [ADDR_W-1:0] read_idx;

  assign col_clamp = (in_col >= 8'(tcw_pkg::SCREEN_COLS)) ?
                     COL_W'(tcw_pkg::SCREEN_COLS - 1) : in_col[COL_W-1:0];
  assign row_clamp = (in_row >= 8'(tcw_pkg::SCREEN_ROWS)) ?
                     ROW_W'(tcw_pkg::SCREEN_ROWS - 1) : in_row[ROW_W-1:0];
  assign read_idx  = lin_of(row_clamp, col_clamp);

  // --------------------------------------------------------------------------
  // Put char: cursor movement and the cell it writes
  // --------------------------------------------------------------------------
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [COL_W-1:0]  pc_col;
  logic [ROW_W:0]    pc_row;
  logic              pc_we;
  logic [ADDR_W-1:0] pc_waddr;
  logic [CELL_W-1:0] pc_wdata;
  logic              pc_scroll;
  logic [CELL_W-1:0] blank_cell;

  assign blank_cell = {blank_color_r, tcw_pkg::SPACE_CHAR};
  assign col_inc    = (COL_W+1)'(cur_col_r) + (COL_W+1)'(1);
  assign row_inc    = (ROW_W+1)'(cur_row_r) + (ROW_W+1)'(1);

  always_comb begin
    pc_col   = cur_col_r;
    pc_row   = (ROW_W+1)'(cur_row_r);
    pc_we    = 1'b0;
    pc_waddr = lin_r;
    pc_wdata = {in_color, in_char_code};
    if ((in_char_code == tcw_pkg::CH_NEWLINE) || (in_char_code == tcw_pkg::CH_RETURN)) begin
      pc_col = '0;
      pc_row = row_inc;
    end else if (in_char_code == tcw_pkg::CH_BACKSPACE) begin
      // Step back one cell; at home stay and blank cell zero.
      if (cur_col_r != '0) begin
        pc_col = cur_col_r - COL_W'(1);
      end else if (cur_row_r != '0) begin
        pc_col = COL_W'(tcw_pkg::SCREEN_COLS - 1);
        pc_row = (ROW_W+1)'(cur_row_r) - (ROW_W+1)'(1);
      end
      pc_we    = 1'b1;
      pc_waddr = (lin_r == '0) ? '0 : lin_r - ADDR_W'(1);
      pc_wdata = blank_cell;
    end else begin
      pc_we = 1'b1;
      if (col_inc == (COL_W+1)'(tcw_pkg::SCREEN_COLS)) begin
        pc_col = '0;
        pc_row = row_inc;
      end else begin
        pc_col = col_inc[COL_W-1:0];
      end
    end
    pc_scroll = (pc_row == (ROW_W+1)'(tcw_pkg::SCREEN_ROWS));
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (scan_r == tcw_pkg::LAST_CELL) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (act)
            tcw_pkg::ACT_PUT:    if (pc_scroll) state_nxt = tcw_pkg::ST_COPY;
            tcw_pkg::ACT_CLEAR:  state_nxt = tcw_pkg::ST_BLANK;
            tcw_pkg::ACT_READ:   state_nxt = tcw_pkg::ST_READ;
            default:             state_nxt = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        if (out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_COPY: begin
        if (scan_r == tcw_pkg::COPY_LAST) state_nxt = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (scan_r == tcw_pkg::LAST_CELL) state_nxt = tcw_pkg::ST_FIN;
      end
      tcw_pkg::ST_FIN: begin
        if (out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs
  // --------------------------------------------------------------------------
  logic              idle_we;
  logic [ADDR_W-1:0] idle_waddr;
  logic [CELL_W-1:0] idle_wdata;

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    scan_nxt      = scan_r;
    fill_val_nxt  = fill_val_r;
    rd_addr_nxt   = rd_addr_r;
    wr_pend_nxt   = 1'b0;
    wr_copy_nxt   = 1'b0;
    wr_addr_nxt   = scan_r;
    idle_we       = 1'b0;
    idle_waddr    = pc_waddr;
    idle_wdata    = pc_wdata;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_cell_nxt  = out_cell_r;
    mem_raddr     = rd_addr_r;

    case (state_r)
      tcw_pkg::ST_INIT: begin
        // Sweep the reset value through the store; each write lands in the cycle after its address is set.
        wr_pend_nxt = 1'b1;
        scan_nxt    = scan_r + ADDR_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        mem_raddr = read_idx;
        if (accept) begin
          case (act)
            tcw_pkg::ACT_PUT: begin
              idle_we     = pc_we;
              cur_col_nxt = pc_col;
              if (pc_scroll) begin
                cur_row_nxt  = ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
                scan_nxt     = '0;
                fill_val_nxt = blank_cell;
              end else begin
                cur_row_nxt   = pc_row[ROW_W-1:0];
                out_valid_nxt = 1'b1;
                out_pos_nxt   = POS_W'(lin_of(pc_row[ROW_W-1:0], pc_col));
                out_cell_nxt  = '0;
              end
            end
            tcw_pkg::ACT_CLEAR: begin
              cur_col_nxt  = '0;
              cur_row_nxt  = '0;
              scan_nxt     = '0;
              fill_val_nxt = blank_cell;
            end
            tcw_pkg::ACT_SETCUR: begin
              cur_col_nxt   = col_clamp;
              cur_row_nxt   = row_clamp;
              out_valid_nxt = 1'b1;
              out_pos_nxt   = POS_W'(read_idx);
              out_cell_nxt  = '0;
            end
            default: begin
              // Read: hold the address so the data stays valid while stalled.
              rd_addr_nxt = read_idx;
            end
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(lin_r);
          out_cell_nxt  = rd_data_r;
        end
      end
      tcw_pkg::ST_COPY: begin
        // Read one row ahead, write the cell back one row up next cycle.
        mem_raddr   = scan_r + ADDR_W'(tcw_pkg::SCREEN_COLS);
        wr_pend_nxt = 1'b1;
        wr_copy_nxt = 1'b1;
        scan_nxt    = (scan_r == tcw_pkg::COPY_LAST) ? tcw_pkg::TAIL_FIRST :
                      scan_r + ADDR_W'(1);
      end
      tcw_pkg::ST_BLANK: begin
        wr_pend_nxt = 1'b1;
        scan_nxt    = scan_r + ADDR_W'(1);
      end
      tcw_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = POS_W'(lin_r);
          out_cell_nxt  = '0;
        end
      end
      default: begin
        wr_pend_nxt = 1'b0;
      end
    endcase

    lin_nxt = lin_of(cur_row_nxt, cur_col_nxt);
  end

  // Sweep writes take priority; the input side is stalled while one is pending.
  assign mem_we    = wr_pend_r || idle_we;
  assign mem_waddr = wr_pend_r ? wr_addr_r : idle_waddr;
  assign mem_wdata = wr_pend_r ? (wr_copy_r ? rd_data_r : fill_val_r) : idle_wdata;

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // Control and payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tcw_pkg::ST_INIT;
      blank_color_r <= tcw_pkg::BLANK_COLOR_RST;
      cur_col_r     <= '0;
      cur_row_r     <= '0;
      lin_r         <= '0;
      scan_r        <= '0;
      rd_addr_r     <= '0;
      fill_val_r    <= tcw_pkg::RESET_CELL;
      wr_pend_r     <= 1'b0;
      wr_copy_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      lin_r       <= lin_nxt;
      scan_r      <= scan_nxt;
      rd_addr_r   <= rd_addr_nxt;
      fill_val_r  <= fill_val_nxt;
      wr_pend_r   <= wr_pend_nxt;
      wr_copy_r   <= wr_copy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        blank_color_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cell_r <= out_cell_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Row copy never reads the cell it writes in the same cycle.
  a_copy_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_COPY && wr_pend_r) |-> (mem_raddr != mem_waddr))
    else $error("scroll copy reads the cell being written");

  // A scroll always leaves the cursor on the last row.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::ST_COPY && $past(state_r) == tcw_pkg::ST_IDLE)
      |-> (cur_row_r == ROW_W'(tcw_pkg::SCREEN_ROWS - 1)))
    else $error("scroll entered with the cursor off the last row");

  // The linear cursor always tracks column and row.
  a_lin_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (lin_r == lin_of(cur_row_r, cur_col_r)))
    else $error("linear cursor out of step with column and row");

  // A set cursor item yields its result in the next cycle.
  a_setcur_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && act == tcw_pkg::ACT_SETCUR) |=> (out_valid_r && out_pos_r == POS_W'(lin_r)))
    else $error("set cursor result missing or wrong");

endmodule
`default_nettype wire

/* verif/text_console_writer_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer. It keeps its own copy
// of the frame store, the cursor and the blank color, and works out the
// cursor position and the cell contents that each item must return. A short
// directed run covers the clamps, backspace at home, wrap, scroll and clear.
// Random phases follow, each under its own blank color, with gaps and
// stalls on both sides in every phase but one.
// ----------------------------------------------------------------------------
module text_console_writer_test;

  // Scrolls and clears walk the whole store, so cap them per phase
  localparam int LONG_PER_PHASE = 16;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 178;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    tcw_pkg::tcw_action_t       action;
    logic [tcw_pkg::BYTE_W-1:0] ch;
    logic [tcw_pkg::BYTE_W-1:0] color;
    logic [tcw_pkg::BYTE_W-1:0] col;
    logic [tcw_pkg::BYTE_W-1:0] row;
  } console_cmd_t;

  typedef struct packed {
    logic [tcw_pkg::POS_W-1:0]  pos;
    logic [tcw_pkg::CELL_W-1:0] cell_val;
  } console_view_t;

  typedef struct packed {
    console_cmd_t  cmd;
    console_view_t view;
  } console_job_t;

  // Clock, reset and every block input start at known values
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        in_action    = tcw_pkg::ACT_READ;
  logic [7:0]        in_char_code = '0;
  logic [7:0]        in_color     = '0;
  logic [7:0]        in_col       = '0;
  logic [7:0]        in_row       = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [10:0]       out_cursor_pos;
  logic [15:0]       out_cell_data;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data     = '0;

  // Screen copy kept by the bench
  logic [tcw_pkg::CELL_W-1:0] screen [tcw_pkg::CELL_COUNT];
  int                         cur_col;
  int                         cur_row;
  logic [tcw_pkg::BYTE_W-1:0] blank_attr;

  console_job_t      pending_q [$];   // items waiting for the driver
  console_view_t     result_q  [$];   // results owed by accepted items
  console_job_t      on_bus;
  console_view_t     want;

  bit                no_gaps      = 1'b0;
  int                scroll_count = 0;
  int                clear_count  = 0;
  int                read_count   = 0;
  int                long_mark    = 0;
  int                accepted     = 0;
  int                color_sets   = 0;
  int                mismatches   = 0;
  int unsigned       cycle_count  = 0;
  int unsigned       cycle_limit  = 4 * (tcw_pkg::CELL_COUNT + 1) + 10000;

  text_console_writer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_color       (in_color),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Console predictor
  // --------------------------------------------------------------------------
  function automatic logic [tcw_pkg::CELL_W-1:0] blank_value();
    return {blank_attr, tcw_pkg::SPACE_CHAR};
  endfunction

  // Blank every cell from the given index to the end of the store
  function automatic void blank_from(int first);
    for (int i = first; i < tcw_pkg::CELL_COUNT; i++) begin
      screen[i] = blank_value();
    end
  endfunction

  function automatic int clip_col(logic [tcw_pkg::BYTE_W-1:0] c);
    return (c >= tcw_pkg::SCREEN_COLS) ? tcw_pkg::SCREEN_COLS - 1 : int'(c);
  endfunction

  function automatic int clip_row(logic [tcw_pkg::BYTE_W-1:0] r);
    return (r >= tcw_pkg::SCREEN_ROWS) ? tcw_pkg::SCREEN_ROWS - 1 : int'(r);
  endfunction

  function automatic void put_glyph(logic [tcw_pkg::BYTE_W-1:0] ch,
                                    logic [tcw_pkg::BYTE_W-1:0] attr);
    if (ch == tcw_pkg::CH_NEWLINE || ch == tcw_pkg::CH_RETURN) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == tcw_pkg::CH_BACKSPACE) begin
      // step back, wrapping to the end of the line above; stay put at home
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_row--;
        cur_col = tcw_pkg::SCREEN_COLS - 1;
      end
      screen[cur_row * tcw_pkg::SCREEN_COLS + cur_col] = blank_value();
    end else begin
      screen[cur_row * tcw_pkg::SCREEN_COLS + cur_col] = {attr, ch};
      cur_col++;
      if (cur_col >= tcw_pkg::SCREEN_COLS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    // past the bottom row: move every line up one and blank the last line
    if (cur_row >= tcw_pkg::SCREEN_ROWS) begin
      for (int i = 0; i < (tcw_pkg::SCREEN_ROWS - 1) * tcw_pkg::SCREEN_COLS; i++) begin
        screen[i] = screen[i + tcw_pkg::SCREEN_COLS];
      end
      blank_from((tcw_pkg::SCREEN_ROWS - 1) * tcw_pkg::SCREEN_COLS);
      cur_row = tcw_pkg::SCREEN_ROWS - 1;
      scroll_count++;
    end
  endfunction

  // Apply one item to the screen copy and return what the block must report
  function automatic console_view_t apply_cmd(console_cmd_t cmd);
    console_view_t v;
    v.cell_val = '0;
    case (cmd.action)
      tcw_pkg::ACT_PUT: begin
        put_glyph(cmd.ch, cmd.color);
      end
      tcw_pkg::ACT_CLEAR: begin
        blank_from(0);
        cur_col = 0;
        cur_row = 0;
        clear_count++;
      end
      tcw_pkg::ACT_SETCUR: begin
        cur_col = clip_col(cmd.col);
        cur_row = clip_row(cmd.row);
      end
      default: begin
        // read leaves the cursor where it is
        v.cell_val = screen[clip_row(cmd.row) * tcw_pkg::SCREEN_COLS + clip_col(cmd.col)];
        read_count++;
      end
    endcase
    v.pos = tcw_pkg::POS_W'(cur_row * tcw_pkg::SCREEN_COLS + cur_col);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Predict the item in order and hand it to the driver; grow the cycle
  // limit by four times the slowest correct cost of that item.
  task automatic queue_cmd(tcw_pkg::tcw_action_t act, logic [7:0] ch, logic [7:0] color,
                           logic [7:0] col, logic [7:0] row);
    console_job_t job;
    int           long_before;
    long_before      = scroll_count + clear_count;
    job.cmd.action   = act;
    job.cmd.ch       = ch;
    job.cmd.color    = color;
    job.cmd.col      = col;
    job.cmd.row      = row;
    job.view         = apply_cmd(job.cmd);
    cycle_limit     += (scroll_count + clear_count != long_before) ? 4 * 2100 : 4 * 40;
    pending_q.push_back(job);
  endtask

  // Mostly text with line breaks and backspaces, plus cursor moves, reads
  // and the odd clear. Unused fields carry random noise.
  task automatic queue_random_cmd();
    int                   pick;
    bit                   walks_store;
    tcw_pkg::tcw_action_t act;
    logic [7:0]           ch;
    logic [7:0]           color;
    logic [7:0]           col;
    logic [7:0]           row;
    pick  = $urandom_range(99);
    ch    = $urandom_range(255);
    color = $urandom_range(255);
    col   = $urandom_range(255);
    row   = $urandom_range(255);
    if (pick < 60) begin
      act = tcw_pkg::ACT_PUT;
    end else if (pick < 68) begin
      act = tcw_pkg::ACT_PUT;
      ch  = $urandom_range(1) ? tcw_pkg::CH_NEWLINE : tcw_pkg::CH_RETURN;
    end else if (pick < 75) begin
      act = tcw_pkg::ACT_PUT;
      ch  = tcw_pkg::CH_BACKSPACE;
    end else if (pick < 85) begin
      act = tcw_pkg::ACT_SETCUR;
      if ($urandom_range(1)) col = $urandom_range(tcw_pkg::SCREEN_COLS - 1);
      if ($urandom_range(9) < 6) row = $urandom_range(tcw_pkg::SCREEN_ROWS - 5);
    end else if (pick < 98) begin
      act = tcw_pkg::ACT_READ;
      if ($urandom_range(3) != 0) begin
        col = $urandom_range(tcw_pkg::SCREEN_COLS - 1);
        row = $urandom_range(tcw_pkg::SCREEN_ROWS - 1);
      end
    end else begin
      act = tcw_pkg::ACT_CLEAR;
    end
    // Once the phase has used its share of scrolls and clears, swap any
    // item that would walk the whole store for a move to the upper half
    walks_store = (act == tcw_pkg::ACT_CLEAR) ||
                  (act == tcw_pkg::ACT_PUT && cur_row == tcw_pkg::SCREEN_ROWS - 1 &&
                   ch != tcw_pkg::CH_BACKSPACE &&
                   (ch == tcw_pkg::CH_NEWLINE || ch == tcw_pkg::CH_RETURN ||
                    cur_col == tcw_pkg::SCREEN_COLS - 1));
    if (walks_store && scroll_count + clear_count - long_mark >= LONG_PER_PHASE) begin
      act = tcw_pkg::ACT_SETCUR;
      row = $urandom_range(tcw_pkg::SCREEN_ROWS / 2);
    end
    queue_cmd(act, ch, color, col, row);
  endtask

  // Hold until every queued item is taken and every result has come back;
  // look on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || result_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write the blank color while the block is idle and mirror it
  task automatic write_blank_color(logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid  <= 1'b0;
    blank_attr  = value;
    color_sets++;
  endtask

  task automatic note_mismatch(string what, int exp_val, int got_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch %s: expected 0x%0h, got 0x%0h (item %0d)",
               what, exp_val, got_val, accepted);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next pending item, hold it while stalled, push its
  // result on acceptance. Gaps fall at random unless no_gaps is set.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(on_bus.view);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
          on_bus        = pending_q.pop_front();
          in_valid     <= 1'b1;
          in_action    <= on_bus.cmd.action;
          in_char_code <= on_bus.cmd.ch;
          in_color     <= on_bus.cmd.color;
          in_col       <= on_bus.cmd.col;
          in_row       <= on_bus.cmd.row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall at random, check each taken result against the oldest
  // owed one, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 10);
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        note_mismatch("unowed result, cursor_pos", 0, out_cursor_pos);
      end else begin
        want = result_q.pop_front();
        if (out_cursor_pos !== want.pos) begin
          note_mismatch("cursor_pos", want.pos, out_cursor_pos);
        end
        if (out_cell_data !== want.cell_val) begin
          note_mismatch("cell_data", want.cell_val, out_cell_data);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, result_q.size() + pending_q.size());
      $display("FAIL text_console_writer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] phase_color [PHASES];
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = $urandom_range(255);
    phase_color[3] = $urandom_range(255);
    phase_color[4] = 8'h5A;
    phase_color[5] = $urandom_range(255);
    phase_color[6] = tcw_pkg::BLANK_COLOR_RST;

    // Mirror the reset state: all cells blank, cursor home
    blank_attr = tcw_pkg::BLANK_COLOR_RST;
    blank_from(0);
    cur_col = 0;
    cur_row = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, clamps, backspace paths, wrap, scroll, clear
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_READ,   8'hFF,                 8'hFF, 8'd255, 8'd255);
    queue_cmd(tcw_pkg::ACT_PUT,    8'h41,                 8'h1F, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    tcw_pkg::CH_BACKSPACE, 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    tcw_pkg::CH_BACKSPACE, 8'hFF, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    8'h00,                 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    8'hFF,                 8'hFF, 8'd255, 8'd255);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd1,   8'd0);
    queue_cmd(tcw_pkg::ACT_SETCUR, 8'h00,                 8'h00, 8'd80,  8'd25);
    queue_cmd(tcw_pkg::ACT_PUT,    8'h80,                 8'hA5, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd79,  8'd23);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd0,   8'd24);
    queue_cmd(tcw_pkg::ACT_PUT,    tcw_pkg::CH_NEWLINE,   8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_SETCUR, 8'h00,                 8'h00, 8'd0,   8'd5);
    queue_cmd(tcw_pkg::ACT_PUT,    tcw_pkg::CH_BACKSPACE, 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    tcw_pkg::CH_RETURN,    8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_SETCUR, 8'h00,                 8'h00, 8'd79,  8'd0);
    queue_cmd(tcw_pkg::ACT_PUT,    8'h7A,                 8'h2C, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_SETCUR, 8'h00,                 8'h00, 8'd255, 8'd0);
    queue_cmd(tcw_pkg::ACT_CLEAR,  8'h00,                 8'h00, 8'd0,   8'd0);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd40,  8'd12);
    queue_cmd(tcw_pkg::ACT_READ,   8'h00,                 8'h00, 8'd255, 8'd7);
    queue_cmd(tcw_pkg::ACT_SETCUR, 8'h00,                 8'h00, 8'd0,   8'd0);

    // Random phases, each under a fresh blank color; one runs gap-free
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_blank_color(phase_color[p]);
      no_gaps   = (p == 3);
      long_mark = scroll_count + clear_count;
      cycle_limit += 1000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_random_cmd();
      end
    end

    drain();
    repeat (50) @(posedge clk);

    $display("ran %0d items under %0d blank colors: %0d scrolls, %0d clears, %0d reads",
             accepted, color_sets + 1, scroll_count, clear_count, read_count);
    $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule
`default_nettype wire
